### rtl/mm64_pkg.sv
`timescale 1ns / 1ps

package mm64_pkg;

  localparam logic [63:0] MIX_MUL       = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT     = 47;
  localparam logic [63:0] SEED_AT_RESET = 64'h00000000C70F6907;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [63:0] word;
    logic [63:0] length;
    logic        first;
    logic        mix;
    logic        tail;
    logic        last;
  } mm64_cmd_t;

  typedef struct packed {
    logic      push;
    mm64_cmd_t cmd;
  } mm64_push_t;

  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mm64_mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] product;
  } mm64_mul_rsp_t;

  typedef enum logic [1:0] {
    MS_LO,
    MS_HI_LO,
    MS_LO_HI,
    MS_SUM
  } mm64_mstep_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_LEN,
    B_K1,
    B_K2,
    B_H,
    B_TAIL,
    B_FIN,
    B_OUT
  } mm64_state_t;

endpackage

### rtl/mm64_front.sv
`timescale 1ns / 1ps

module mm64_front
  import mm64_pkg::*;
(
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [63:0] message_length,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        full,
  output mm64_push_t  push
);

  logic        tail;
  logic [63:0] masked;

  assign tail = last_item && !valid_bytes[3] && (valid_bytes != 4'd0);

  always_comb begin
    masked = data_word;
    for (int i = 0; i < 8; i++) begin
      if (tail && !(4'(i) < valid_bytes)) begin
        masked[8*i +: 8] = 8'h00;
      end
    end
  end

  assign in_stall = full;

  always_comb begin
    push.push       = in_valid && !full;
    push.cmd.word   = masked;
    push.cmd.length = message_length;
    push.cmd.first  = first_item;
    push.cmd.mix    = !last_item || valid_bytes[3];
    push.cmd.tail   = tail;
    push.cmd.last   = last_item;
  end

endmodule

### rtl/mm64_queue.sv
`timescale 1ns / 1ps

module mm64_queue
  import mm64_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  mm64_push_t push,
  output logic       full,
  output logic       q_valid,
  output mm64_cmd_t  q_data,
  input  logic       pop
);

  mm64_cmd_t          slots [QDEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;
  logic [QPTR_W-1:0]  wr_ptr_next;
  logic [QPTR_W-1:0]  rd_ptr_next;
  logic [QCNT_W-1:0]  count_next;

  assign full    = (count == QCNT_W'(QDEPTH));
  assign q_valid = (count != '0);
  assign q_data  = slots[rd_ptr];

  always_comb begin
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    count_next  = count;
    if (push.push) begin
      wr_ptr_next = (wr_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
    end
    if (pop) begin
      rd_ptr_next = (rd_ptr == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
    end
    if (push.push && !pop) begin
      count_next = count + 1'b1;
    end else if (pop && !push.push) begin
      count_next = count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

endmodule

### rtl/mm64_mul.sv
`timescale 1ns / 1ps

module mm64_mul
  import mm64_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  mm64_mul_req_t req,
  output mm64_mul_rsp_t rsp
);

  mm64_mstep_t step;
  mm64_mstep_t step_next;
  logic        busy;
  logic        busy_next;
  logic        done;
  logic        done_next;
  logic [63:0] a;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] op_x;
  logic [31:0] op_y;
  logic [63:0] mul_p;

  // low 64 bits: lo*lo + ((hi*lo + lo*hi) << 32)
  always_comb begin
    case (step)
      MS_LO: begin
        op_x = a[31:0];
        op_y = MIX_MUL[31:0];
      end
      MS_HI_LO: begin
        op_x = a[63:32];
        op_y = MIX_MUL[31:0];
      end
      MS_LO_HI: begin
        op_x = a[31:0];
        op_y = MIX_MUL[63:32];
      end
      default: begin
        op_x = a[31:0];
        op_y = MIX_MUL[63:32];
      end
    endcase
    mul_p = {32'd0, op_x} * {32'd0, op_y};
  end

  always_comb begin
    step_next = step;
    busy_next = busy;
    done_next = 1'b0;
    if (req.start) begin
      step_next = MS_LO;
      busy_next = 1'b1;
    end else if (busy) begin
      case (step)
        MS_LO:    step_next = MS_HI_LO;
        MS_HI_LO: step_next = MS_LO_HI;
        MS_LO_HI: step_next = MS_SUM;
        MS_SUM: begin
          step_next = MS_LO;
          busy_next = 1'b0;
          done_next = 1'b1;
        end
        default:  step_next = MS_LO;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= MS_LO;
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      step <= step_next;
      busy <= busy_next;
      done <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a <= req.operand;
    end else if (busy) begin
      prod <= mul_p;
      case (step)
        MS_HI_LO: acc <= prod;
        MS_LO_HI: acc[63:32] <= acc[63:32] + prod[31:0];
        MS_SUM:   acc[63:32] <= acc[63:32] + prod[31:0];
        default:  acc <= acc;
      endcase
    end
  end

  assign rsp.done    = done;
  assign rsp.product = acc;

endmodule

### rtl/mm64_back.sv
`timescale 1ns / 1ps

module mm64_back
  import mm64_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [63:0]   cfg_wdata,
  input  logic          q_valid,
  input  mm64_cmd_t     q_data,
  output logic          pop,
  output mm64_mul_req_t req,
  input  mm64_mul_rsp_t rsp,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [63:0]   hash_value
);

  mm64_state_t state;
  mm64_state_t state_next;
  logic        issued;
  logic        issued_next;
  logic [63:0] seed;
  logic [63:0] h;
  logic [63:0] h_next;
  logic [63:0] k;
  logic [63:0] k_next;
  mm64_cmd_t   cmd;
  mm64_cmd_t   cmd_next;
  logic        out_valid_next;
  logic [63:0] out_hash;
  logic [63:0] out_hash_next;
  logic [63:0] fin;

  function automatic mm64_state_t after_init(input mm64_cmd_t c);
    mm64_state_t s;
    if (c.mix) begin
      s = B_K1;
    end else if (c.tail) begin
      s = B_TAIL;
    end else if (c.last) begin
      s = B_FIN;
    end else begin
      s = B_IDLE;
    end
    return s;
  endfunction

  assign fin = rsp.product ^ (rsp.product >> MIX_SHIFT);

  always_comb begin
    state_next     = state;
    issued_next    = issued;
    h_next         = h;
    k_next         = k;
    cmd_next       = cmd;
    out_valid_next = out_valid && out_stall;
    out_hash_next  = out_hash;
    pop            = 1'b0;
    req.start      = 1'b0;
    req.operand    = cmd.word;

    case (state)
      B_IDLE: begin
        if (q_valid) begin
          pop         = 1'b1;
          cmd_next    = q_data;
          issued_next = 1'b0;
          state_next  = q_data.first ? B_LEN : after_init(q_data);
        end
      end
      B_LEN: begin
        req.operand = cmd.length;
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          h_next      = seed ^ rsp.product;
          issued_next = 1'b0;
          state_next  = after_init(cmd);
        end
      end
      B_K1: begin
        req.operand = cmd.word;
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          k_next      = rsp.product;
          issued_next = 1'b0;
          state_next  = B_K2;
        end
      end
      B_K2: begin
        req.operand = k ^ (k >> MIX_SHIFT);
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          k_next      = rsp.product;
          issued_next = 1'b0;
          state_next  = B_H;
        end
      end
      B_H: begin
        req.operand = h ^ k;
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          h_next      = rsp.product;
          issued_next = 1'b0;
          state_next  = cmd.last ? B_FIN : B_IDLE;
        end
      end
      B_TAIL: begin
        req.operand = h ^ cmd.word;
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          h_next      = rsp.product;
          issued_next = 1'b0;
          state_next  = B_FIN;
        end
      end
      B_FIN: begin
        req.operand = h ^ (h >> MIX_SHIFT);
        if (!issued) begin
          req.start   = 1'b1;
          issued_next = 1'b1;
        end else if (rsp.done) begin
          h_next      = fin;
          issued_next = 1'b0;
          state_next  = B_OUT;
        end
      end
      B_OUT: begin
        if (!out_valid || !out_stall) begin
          out_valid_next = 1'b1;
          out_hash_next  = h;
          state_next     = B_IDLE;
        end
      end
      default: begin
        state_next  = B_IDLE;
        issued_next = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
      seed      <= SEED_AT_RESET;
      h         <= '0;
    end else begin
      state     <= state_next;
      issued    <= issued_next;
      out_valid <= out_valid_next;
      h         <= h_next;
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    k        <= k_next;
    cmd      <= cmd_next;
    out_hash <= out_hash_next;
  end

  assign hash_value = out_hash;

endmodule

### rtl/murmur2_64a_stream_hash.sv
`timescale 1ns / 1ps

// channel  handshake            payload
// in       in_valid / in_stall  data_word, valid_bytes, first_item, last_item, message_length
// out      out_valid/out_stall  hash_value
// cfg      cfg_we               cfg_wdata (hash seed)
//
// every 64-bit multiply runs on one shared 32x32 multiplier
// a word leaves the queue, then runs its multiplies: 3 for a full block,
// 1 more on a first word, 1 for a tail, 1 for the finalizer, and then the hash is posted
// rst clears the queue, the sequencer, the running hash and loads the reset seed
// in_stall rises when the 2-entry queue is full; a pending hash holds only a finished message

module murmur2_64a_stream_hash
  import mm64_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] data_word,
  input  logic [3:0]  valid_bytes,
  input  logic        first_item,
  input  logic        last_item,
  input  logic [63:0] message_length,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] hash_value
);

  mm64_push_t    push;
  logic          full;
  logic          q_valid;
  mm64_cmd_t     q_data;
  logic          pop;
  mm64_mul_req_t req;
  mm64_mul_rsp_t rsp;

  mm64_front u_front (
    .data_word      (data_word),
    .valid_bytes    (valid_bytes),
    .first_item     (first_item),
    .last_item      (last_item),
    .message_length (message_length),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .full           (full),
    .push           (push)
  );

  mm64_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (full),
    .q_valid (q_valid),
    .q_data  (q_data),
    .pop     (pop)
  );

  mm64_mul u_mul (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  mm64_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .pop        (pop),
    .req        (req),
    .rsp        (rsp),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .hash_value (hash_value)
  );

endmodule
